/* rtl/core/huffman_tree_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// huffman tree decoder assertion macros
// Concurrent assertion wrappers for the tree decoder; they compile to nothing
// in synthesis. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define HTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define HTD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HTD_ASSERT(lbl, prop, msg)
`define HTD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/core/htd_pkg.sv */
// ----------------------------------------------------------------------------
// htd_pkg
// Shared constants, codes and types of the huffman tree decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  // default sizes
  localparam int NODE_COUNT_DEF   = 512;
  localparam int MAX_CODE_LEN_DEF = 32;

  // field widths fixed by the interface
  localparam int KIND_W   = 2;
  localparam int SYM_W    = 8;
  localparam int LEN_W    = 6;
  localparam int CODE_W   = 32;
  localparam int STATUS_W = 2;

  // input transaction kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DECODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  // control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_INS_STEP = 4'b0010,
    ST_INS_WAIT = 4'b0100,
    ST_DEC_LEAF = 4'b1000
  } state_t;

endpackage

/* rtl/core/htd_node_ram.sv */
// ----------------------------------------------------------------------------
// htd_node_ram
// Node table storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module htd_node_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/huffman_tree_decoder_top.sv */
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// Huffman code tree held in a node table, with insert, bit-serial decode and
// clear transactions.
// ----------------------------------------------------------------------------
// The tree lives in a single-port-write, single-port-read node RAM with
// registered read data; the root node is kept in flip-flops so reset and
// clear take effect at once, with no clearing pass. A decode transaction
// takes the child index from the registered current node and reads the
// child from the node RAM to test its leaf mark, and that read is the loop
// that sets the bit rate. An insert reads the node RAM for each code bit
// that follows an existing branch and allocates a new node for each code
// bit that does not, then writes the leaf. Clear and the unused kind finish
// in the idle state. A result that waits in the output register stalls only
// a transaction that must produce a result of its own.
module huffman_tree_decoder_top #(
  parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [htd_pkg::KIND_W-1:0]    in_kind,
  input  logic [htd_pkg::SYM_W-1:0]     in_symbol_in,
  input  logic [htd_pkg::LEN_W-1:0]     in_code_length,
  input  logic [htd_pkg::CODE_W-1:0]    in_code_bits,
  input  logic                          in_data_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [htd_pkg::STATUS_W-1:0]  out_status,
  output logic [htd_pkg::SYM_W-1:0]     out_symbol_out
);

  import htd_pkg::*;

`include "huffman_tree_decoder_top_assert.svh"

  localparam int IDXW = $clog2(NODE_COUNT);
  localparam int REMW = $clog2(MAX_CODE_LEN + 1);
  localparam int NW   = 2 * IDXW + 1 + SYM_W;
  localparam logic [6:0]    MAX_LEN7 = 7'(MAX_CODE_LEN);
  localparam logic [IDXW:0] FULL_CNT = (IDXW + 1)'(NODE_COUNT);

  typedef struct packed {
    logic [IDXW-1:0]  left;
    logic [IDXW-1:0]  right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  localparam node_t EMPTY_NODE = '0;

  // registers
  state_t              state_r, state_nxt;
  logic [IDXW-1:0]     walk_r, walk_nxt;
  node_t               cur_r, cur_nxt;
  node_t               root_r, root_nxt;
  logic [IDXW:0]       used_r, used_nxt;
  logic [IDXW-1:0]     at_r, at_nxt;
  node_t               data_r, data_nxt;
  logic                dirty_r, dirty_nxt;
  logic [REMW-1:0]     rem_r, rem_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [IDXW-1:0]     child_r, child_nxt;
  logic                miss_r, miss_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;

  // node ram port
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [NW-1:0]   mem_wdata;
  logic            mem_re;
  logic [IDXW-1:0] mem_raddr;
  logic [NW-1:0]   mem_rdata;
  node_t           rd_node;

  // helpers
  node_t           cur_node;
  logic [IDXW-1:0] dec_child;
  logic [6:0]      len7;
  logic [6:0]      pos7;
  logic            ins_bit;
  logic [IDXW-1:0] ins_child;
  logic            node_full;
  logic            can_emit;
  logic            emit;
  logic [STATUS_W-1:0] emit_status;
  logic [SYM_W-1:0]    emit_sym;
  logic            wb_en;
  node_t           wb_node;
  logic            need_emit;

  htd_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NW)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_node = node_t'(mem_rdata);

  // current decode node and its child along the incoming bit
  assign cur_node  = (walk_r == '0) ? root_r : cur_r;
  assign dec_child = in_data_bit ? cur_node.right : cur_node.left;

  // next insert code bit, first bit at the top
  assign len7      = {1'b0, in_code_length};
  assign pos7      = 7'(rem_r) - 7'd1;
  assign ins_bit   = (pos7 < 7'd32) ? code_r[pos7[4:0]] : 1'b0;
  assign ins_child = ins_bit ? data_r.right : data_r.left;
  assign node_full = (used_r == FULL_CNT);

  assign can_emit  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    walk_nxt    = walk_r;
    cur_nxt     = cur_r;
    root_nxt    = root_r;
    used_nxt    = used_r;
    at_nxt      = at_r;
    data_nxt    = data_r;
    dirty_nxt   = dirty_r;
    rem_nxt     = rem_r;
    code_nxt    = code_r;
    sym_nxt     = sym_r;
    child_nxt   = child_r;
    miss_nxt    = miss_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    emit        = 1'b0;
    emit_status = STATUS_OK;
    emit_sym    = '0;
    wb_en       = 1'b0;
    wb_node     = data_r;
    need_emit   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_INSERT: begin
              at_nxt    = '0;
              data_nxt  = root_r;
              dirty_nxt = 1'b0;
              rem_nxt   = (len7 > MAX_LEN7) ? REMW'(MAX_CODE_LEN) : REMW'(in_code_length);
              code_nxt  = in_code_bits;
              sym_nxt   = in_symbol_in;
              state_nxt = ST_INS_STEP;
            end
            KIND_DECODE: begin
              child_nxt = dec_child;
              miss_nxt  = (dec_child == '0);
              mem_re    = (dec_child != '0);
              mem_raddr = dec_child;
              state_nxt = ST_DEC_LEAF;
            end
            KIND_CLEAR: begin
              root_nxt = EMPTY_NODE;
              used_nxt = (IDXW + 1)'(1);
              walk_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // leaf test of the child just read
      ST_DEC_LEAF: begin
        need_emit = miss_r || rd_node.leaf;
        if (!need_emit) begin
          walk_nxt  = child_r;
          cur_nxt   = rd_node;
          state_nxt = ST_IDLE;
        end else if (can_emit) begin
          emit        = 1'b1;
          emit_status = miss_r ? STATUS_MISSING : STATUS_OK;
          emit_sym    = miss_r ? '0 : rd_node.sym;
          walk_nxt    = '0;
          state_nxt   = ST_IDLE;
        end
      end

      // one code bit of an insert
      ST_INS_STEP: begin
        if (rem_r == '0) begin
          wb_en        = 1'b1;
          wb_node      = data_r;
          wb_node.leaf = 1'b1;
          wb_node.sym  = sym_r;
          state_nxt    = ST_IDLE;
        end else if (ins_child != '0) begin
          wb_en     = dirty_r;
          mem_re    = 1'b1;
          mem_raddr = ins_child;
          child_nxt = ins_child;
          state_nxt = ST_INS_WAIT;
        end else if (node_full) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_status = STATUS_FULL;
            wb_en       = dirty_r;
            state_nxt   = ST_IDLE;
          end
        end else begin
          wb_en = 1'b1;
          if (ins_bit) begin
            wb_node.right = used_r[IDXW-1:0];
          end else begin
            wb_node.left = used_r[IDXW-1:0];
          end
          at_nxt    = used_r[IDXW-1:0];
          data_nxt  = EMPTY_NODE;
          dirty_nxt = 1'b1;
          used_nxt  = used_r + (IDXW + 1)'(1);
          rem_nxt   = rem_r - REMW'(1);
        end
      end

      // existing child arrives from the node ram
      ST_INS_WAIT: begin
        at_nxt    = child_r;
        data_nxt  = rd_node;
        dirty_nxt = 1'b0;
        rem_nxt   = rem_r - REMW'(1);
        state_nxt = ST_INS_STEP;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // write back of the insert node: root in flops, others in ram
    if (wb_en) begin
      if (at_r == '0) begin
        root_nxt = wb_node;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = at_r;
        mem_wdata = NW'(wb_node);
        if (at_r == walk_r) begin
          cur_nxt = wb_node;
        end
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_sym_nxt    = out_sym_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_sym_nxt    = emit_sym;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_r      <= '0;
      root_r      <= EMPTY_NODE;
      used_r      <= (IDXW + 1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      root_r      <= root_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    at_r         <= at_nxt;
    data_r       <= data_nxt;
    dirty_r      <= dirty_nxt;
    rem_r        <= rem_nxt;
    code_r       <= code_nxt;
    sym_r        <= sym_nxt;
    child_r      <= child_nxt;
    miss_r       <= miss_nxt;
    out_status_r <= out_status_nxt;
    out_sym_r    <= out_sym_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_symbol_out = out_sym_r;

  // checks
  `HTD_ASSERT(a_used_range, (used_r != '0) && (used_r <= FULL_CNT), "node count out of range")
  `HTD_ASSERT(a_walk_alloc, (walk_r == '0) || ((IDXW + 1)'(walk_r) < used_r), "walk on free node")
  `HTD_ASSERT_NEVER(a_ram_root_write, mem_we && (mem_waddr == '0), "root written to node ram")
  `HTD_ASSERT(a_emit_state, emit |-> (state_r == ST_DEC_LEAF || state_r == ST_INS_STEP), "bad emit")

endmodule
